// ===== hw/rtl/remd_pkg.sv =====
// ============================================================================
// remd_pkg
// Shared types and constants for the rotated ellipse minimum distance block.
// ============================================================================
package remd_pkg;

    localparam int DEF_MAX_DIMS    = 8;
    localparam int DEF_MAX_CENTERS = 8;
    localparam int DIST_W          = 48;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DIMS    = 2'd0;
    localparam logic [1:0] REG_CENTERS = 2'd1;
    localparam logic [1:0] REG_ROOT    = 2'd2;

    typedef enum logic [1:0] {
        ACT_BASIS  = 2'd0,
        ACT_CENTER = 2'd1,
        ACT_WIDTH  = 2'd2,
        ACT_POINT  = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [2:0]         row;
        logic [2:0]         column;
        logic signed [31:0] value;
        logic               last;
    } t_in_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_res;

endpackage

// ===== hw/rtl/remd_ram.sv =====
// ============================================================================
// remd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module remd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rotated_ellipse_min_distance.sv =====
// ============================================================================
// rotated_ellipse_min_distance
// Nearest centre distance in a rotated frame with per-axis widths.
// ============================================================================
// Requests arrive on the input channel (i_in_valid / o_in_stall). A request
// either writes one entry of the basis, centre or width table, or delivers
// one point coordinate. Table writes and plain coordinates are accepted
// back to back while no evaluation runs. A coordinate marked last starts an
// evaluation, during which o_in_stall is held high.
// The evaluation is a sequencer around the table memories: the projection
// steps through each basis entry with a read, a multiply and an accumulate.
// Each centre axis then goes through a read, a subtract, a check, a
// restoring divider, a square and an accumulate. In root mode (REG_ROOT)
// a square root follows, and the result is then loaded into the output
// register.
// The result sits in an output register (o_out_valid / i_out_stall). While
// the receiver stalls, new table writes and coordinates are still taken;
// only the end of the next evaluation waits for the register to free up.
// Reset clears the configuration registers to dims 8, one centre, squared
// mode, and empties the output register. Table contents are not cleared
// and must be written before they are used.
// ============================================================================
module rotated_ellipse_min_distance #(
    parameter int MAX_DIMS    = remd_pkg::DEF_MAX_DIMS,
    parameter int MAX_CENTERS = remd_pkg::DEF_MAX_CENTERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  remd_pkg::t_in_req  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output remd_pkg::t_out_res o_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DW  = $clog2(MAX_DIMS);
    localparam int CW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int BAW = $clog2(MAX_DIMS * MAX_DIMS);
    localparam int TAW = $clog2(MAX_CENTERS * MAX_DIMS);
    localparam logic [47:0] DIST_MAX = '1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_PRD  = 12'b000000000010,
        S_PMUL = 12'b000000000100,
        S_PACC = 12'b000000001000,
        S_DRD  = 12'b000000010000,
        S_DSUB = 12'b000000100000,
        S_DCHK = 12'b000001000000,
        S_DIV  = 12'b000010000000,
        S_SQ   = 12'b000100000000,
        S_DACC = 12'b001000000000,
        S_ROOT = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [3:0] r_dims;
    logic [3:0] r_cents;
    logic       r_root_en;

    // Sequencer counters.
    logic [DW-1:0] r_i;
    logic [DW-1:0] r_j;
    logic [CW-1:0] r_c;
    logic [4:0]    r_k;

    // Datapath registers.
    logic signed [63:0] r_prod;
    logic signed [38:0] r_acc;
    logic signed [38:0] r_proj [MAX_DIMS];
    logic [39:0]        r_ad;
    logic [31:0]        r_aw;
    logic               r_tsat;
    logic [31:0]        r_rem;
    logic [31:0]        r_lo;
    logic [31:0]        r_quo;
    logic [63:0]        r_sq;
    logic [47:0]        r_sum;
    logic               r_sat;
    logic [47:0]        r_best;
    logic               r_best_flag;
    logic [63:0]        r_x;
    logic [63:0]        r_r;
    logic [63:0]        r_bit;
    logic               r_out_vld;
    remd_pkg::t_out_res r_out;

    // ---------------------------------------------------------------- clamps
    logic [DW-1:0] dims_last;
    logic [CW-1:0] cents_last;

    always_comb begin
        logic [31:0] dv;
        logic [31:0] cv;
        dv = 32'(r_dims);
        cv = 32'(r_cents);
        if (dv == 32'd0) begin
            dims_last = '0;
        end else if (dv > 32'(MAX_DIMS)) begin
            dims_last = DW'(MAX_DIMS - 1);
        end else begin
            dims_last = DW'(dv - 32'd1);
        end
        if (cv == 32'd0) begin
            cents_last = '0;
        end else if (cv > 32'(MAX_CENTERS)) begin
            cents_last = CW'(MAX_CENTERS - 1);
        end else begin
            cents_last = CW'(cv - 32'd1);
        end
    end

    // ------------------------------------------------------- write decoding
    logic        in_acc;
    logic [15:0] wr_row_addr;
    logic [15:0] wr_col;
    logic        row_ok_d;
    logic        row_ok_c;
    logic        col_ok;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign wr_col      = 16'(i_in_data.column);
    assign wr_row_addr = 16'(i_in_data.row) * 16'(MAX_DIMS) + wr_col;
    assign col_ok      = wr_col < 16'(MAX_DIMS);
    assign row_ok_d    = 16'(i_in_data.row) < 16'(MAX_DIMS);
    assign row_ok_c    = 16'(i_in_data.row) < 16'(MAX_CENTERS);

    logic we_basis;
    logic we_cent;
    logic we_width;
    logic we_point;

    always_comb begin
        we_basis = 1'b0;
        we_cent  = 1'b0;
        we_width = 1'b0;
        we_point = 1'b0;
        if (in_acc) begin
            unique case (i_in_data.action)
                remd_pkg::ACT_BASIS:  we_basis = row_ok_d && col_ok;
                remd_pkg::ACT_CENTER: we_cent  = row_ok_c && col_ok;
                remd_pkg::ACT_WIDTH:  we_width = row_ok_c && col_ok;
                remd_pkg::ACT_POINT:  we_point = col_ok;
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------------- memories
    logic [BAW-1:0] basis_raddr;
    logic [TAW-1:0] tab_raddr;
    logic [31:0]    basis_rd;
    logic [31:0]    point_rd;
    logic [31:0]    cent_rd;
    logic [31:0]    width_rd;

    assign basis_raddr = BAW'(32'(r_i) * 32'(MAX_DIMS) + 32'(r_j));
    assign tab_raddr   = TAW'(32'(r_c) * 32'(MAX_DIMS) + 32'(r_i));

    remd_ram #(.WIDTH(32), .DEPTH(MAX_DIMS * MAX_DIMS)) u_basis (
        .i_clk   (i_clk),
        .i_we    (we_basis),
        .i_waddr (wr_row_addr[BAW-1:0]),
        .i_wdata (i_in_data.value),
        .i_raddr (basis_raddr),
        .o_rdata (basis_rd)
    );

    remd_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_point (
        .i_clk   (i_clk),
        .i_we    (we_point),
        .i_waddr (wr_col[DW-1:0]),
        .i_wdata (i_in_data.value),
        .i_raddr (r_j),
        .o_rdata (point_rd)
    );

    remd_ram #(.WIDTH(32), .DEPTH(MAX_CENTERS * MAX_DIMS)) u_cent (
        .i_clk   (i_clk),
        .i_we    (we_cent),
        .i_waddr (wr_row_addr[TAW-1:0]),
        .i_wdata (i_in_data.value),
        .i_raddr (tab_raddr),
        .o_rdata (cent_rd)
    );

    remd_ram #(.WIDTH(32), .DEPTH(MAX_CENTERS * MAX_DIMS)) u_width (
        .i_clk   (i_clk),
        .i_we    (we_width),
        .i_waddr (wr_row_addr[TAW-1:0]),
        .i_wdata (i_in_data.value),
        .i_raddr (tab_raddr),
        .o_rdata (width_rd)
    );

    // ------------------------------------------------------ datapath helpers
    // Each product is rounded half up to Q16.16 and the projection summed.
    logic signed [63:0] prod_rnd;
    logic signed [63:0] prod_term;
    logic signed [38:0] n_acc;

    assign prod_rnd  = r_prod + 64'sd536870912;
    assign prod_term = prod_rnd >>> 30;
    assign n_acc     = ((r_j == '0) ? 39'sd0 : r_acc) + 39'(prod_term);

    logic signed [39:0] diff;
    logic signed [31:0] wv;

    assign diff = 40'($signed(cent_rd)) - 40'(r_proj[r_i]);
    assign wv   = $signed(width_rd);

    // One quotient bit per cycle.
    logic [32:0] rem_sh;
    logic        rem_ge;

    assign rem_sh = {r_rem, r_lo[31]};
    assign rem_ge = rem_sh >= {1'b0, r_aw};

    logic [48:0] sum_ext;
    logic        n_sat;
    logic [47:0] fin;
    logic        take_c;
    logic [47:0] n_best;

    assign sum_ext = {1'b0, r_sum} + {1'b0, r_sq[63:16]};
    assign n_sat   = r_sat || r_tsat || sum_ext[48];
    assign fin     = n_sat ? DIST_MAX : sum_ext[47:0];
    assign take_c  = (r_c == '0) || (fin < r_best);
    assign n_best  = take_c ? fin : r_best;

    // Integer square root, one result bit (two bits of the radicand) per step.
    logic [63:0] root_try;
    assign root_try = r_r + r_bit;

    logic out_free;
    assign out_free = !r_out_vld || !i_out_stall;

    // ------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dims    <= 4'd8;
            r_cents   <= 4'd1;
            r_root_en <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    remd_pkg::REG_DIMS:    r_dims    <= pwdata[3:0];
                    remd_pkg::REG_CENTERS: r_cents   <= pwdata[3:0];
                    remd_pkg::REG_ROOT:    r_root_en <= pwdata[0];
                    default: ;
                endcase
            end
            // A finished evaluation refills the output register in the same
            // cycle as the receiver takes the previous result.
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.action == remd_pkg::ACT_POINT
                        && i_in_data.last) begin
                        r_state <= S_PRD;
                    end
                end
                S_PRD:  r_state <= S_PMUL;
                S_PMUL: r_state <= S_PACC;
                S_PACC: begin
                    if (r_j == dims_last && r_i == dims_last) begin
                        r_state <= S_DRD;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_DRD:  r_state <= S_DSUB;
                S_DSUB: r_state <= S_DCHK;
                S_DCHK: r_state <= S_DIV;
                S_DIV: begin
                    if (r_k == 5'd31) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_DACC;
                S_DACC: begin
                    if (r_i == dims_last && r_c == cents_last) begin
                        r_state <= r_root_en ? S_ROOT : S_DONE;
                    end else begin
                        r_state <= S_DRD;
                    end
                end
                S_ROOT: begin
                    if (r_k == 5'd31) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i <= '0;
                r_j <= '0;
            end
            S_PMUL: begin
                r_prod <= 64'($signed(point_rd)) * 64'($signed(basis_rd));
            end
            S_PACC: begin
                r_acc <= n_acc;
                if (r_j == dims_last) begin
                    r_proj[r_i] <= n_acc;
                    r_j <= '0;
                    if (r_i == dims_last) begin
                        r_i   <= '0;
                        r_c   <= '0;
                        r_sum <= '0;
                        r_sat <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            S_DSUB: begin
                r_ad <= diff[39] ? 40'(-diff) : 40'(diff);
                r_aw <= wv[31] ? 32'(-wv) : 32'(wv);
            end
            S_DCHK: begin
                // A zero width or a quotient of 2^32 or more saturates.
                r_tsat <= (r_aw == 32'd0) || ({8'd0, r_ad} >= {r_aw, 16'd0});
                r_rem  <= {8'd0, r_ad[39:16]};
                r_lo   <= {r_ad[15:0], 16'd0};
                r_k    <= '0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_aw}) : rem_sh[31:0];
                r_lo  <= {r_lo[30:0], 1'b0};
                r_quo <= {r_quo[30:0], rem_ge};
                r_k   <= r_k + 1'b1;
            end
            S_SQ: begin
                r_sq <= 64'(r_quo) * 64'(r_quo);
            end
            S_DACC: begin
                if (r_i == dims_last) begin
                    r_best <= n_best;
                    if (take_c) begin
                        r_best_flag <= n_sat;
                    end
                    r_i   <= '0;
                    r_c   <= r_c + 1'b1;
                    r_sum <= '0;
                    r_sat <= 1'b0;
                    r_x   <= {n_best, 16'd0};
                    r_r   <= '0;
                    r_bit <= 64'd1 << 62;
                    r_k   <= '0;
                end else begin
                    r_i   <= r_i + 1'b1;
                    r_sum <= fin;
                    r_sat <= n_sat;
                end
            end
            S_ROOT: begin
                if (r_x >= root_try) begin
                    r_x <= r_x - root_try;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.distance <= r_root_en ? r_r[47:0] : r_best;
                    r_out.overflow <= r_best_flag;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- ports
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            remd_pkg::REG_DIMS:    prdata = {28'd0, r_dims};
            remd_pkg::REG_CENTERS: prdata = {28'd0, r_cents};
            remd_pkg::REG_ROOT:    prdata = {31'd0, r_root_en};
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the rotated ellipse minimum distance block.
// ============================================================================
// Tables and the point buffer are filled first, so that no entry is read
// before it has been written. A directed phase then covers the extreme
// settings, zero and negative widths and extreme values. Random phases
// follow, each with its own register setting. A class computes the expected
// distance for every accepted last coordinate and checks every result in order.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import remd_pkg::*;

    localparam longint unsigned DIST_TOP = (64'd1 << 48) - 64'd1;
    localparam int              LIMIT    = 40000000;

    // Scoreboard: a private copy of the tables and registers, a predictor
    // and the queue of distances still owed by the block.
    class distance_board;
        logic signed [31:0] basis [8][8];
        logic signed [31:0] centre [8][8];
        logic signed [31:0] width [8][8];
        logic signed [31:0] point [8];
        logic [3:0]         dims_reg;
        logic [3:0]         cent_reg;
        logic               root_reg;
        t_out_res           owed [$];
        int                 errors;

        function new();
            dims_reg = 4'd8;
            cent_reg = 4'd1;
            root_reg = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_DIMS:    dims_reg = val[3:0];
                REG_CENTERS: cent_reg = val[3:0];
                REG_ROOT:    root_reg = val[0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function t_out_res nearest();
            longint          proj [8];
            longint          acc;
            longint          diff;
            longint          w;
            longint unsigned ad;
            longint unsigned aw;
            longint unsigned q;
            longint unsigned term;
            longint unsigned sum;
            longint unsigned best;
            bit              sat;
            bit              best_sat;
            int              dims;
            int              ncent;
            t_out_res        res;
            dims  = (dims_reg == 0) ? 1 : (dims_reg > 8 ? 8 : dims_reg);
            ncent = (cent_reg == 0) ? 1 : (cent_reg > 8 ? 8 : cent_reg);
            best = 0;
            best_sat = 0;
            for (int i = 0; i < dims; i++) begin
                acc = 0;
                for (int j = 0; j < dims; j++)
                    acc += (longint'(point[j]) * longint'(basis[i][j]) + (64'sd1 <<< 29))
                           >>> 30;
                proj[i] = acc;
            end
            for (int c = 0; c < ncent; c++) begin
                sum = 0;
                sat = 0;
                for (int i = 0; i < dims && !sat; i++) begin
                    diff = longint'(centre[c][i]) - proj[i];
                    w    = longint'(width[c][i]);
                    ad   = (diff < 0) ? -diff : diff;
                    aw   = (w < 0) ? -w : w;
                    if (aw == 0) begin
                        sat = 1;
                    end else begin
                        q = (ad << 16) / aw;
                        if (q >= (64'd1 << 32)) begin
                            sat = 1;
                        end else begin
                            term = (q * q) >> 16;
                            if (term > DIST_TOP - sum) sat = 1;
                            else sum += term;
                        end
                    end
                end
                if (sat) sum = DIST_TOP;
                if (c == 0 || sum < best) begin
                    best = sum;
                    best_sat = sat;
                end
            end
            if (root_reg) best = int_sqrt(best << 16);
            res.distance = best[47:0];
            res.overflow = best_sat;
            return res;
        endfunction

        // Notes an accepted request and, on a last coordinate, the distance it owes.
        function void note_request(t_in_req r);
            case (r.action)
                ACT_BASIS:  basis[r.row][r.column] = r.value;
                ACT_CENTER: centre[r.row][r.column] = r.value;
                ACT_WIDTH:  width[r.row][r.column] = r.value;
                default: begin
                    point[r.column] = r.value;
                    if (r.last) owed.push_back(nearest());
                end
            endcase
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result distance=%h overflow=%b",
                         $realtime, got.distance, got.overflow);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.distance !== want.distance) begin
                $display("%0t: distance expected %h actual %h",
                         $realtime, want.distance, got.distance);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %b actual %b",
                         $realtime, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_req     i_in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_res    o_out_data;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distance_board board = new();
    t_in_req       send_queue [$];
    int            burst_left = 0;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            stall_left = 0;
    int            cycles = 0;
    int            item_count = 0;

    rotated_ellipse_min_distance i_dut (.*);

    always #1 i_clk = ~i_clk;

    // The cycle counter ends a run that has hung.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sender: requests leave the queue in bursts of random length, with
    // random gaps between the bursts. A stalled request is held unchanged.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.note_request(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (send_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= send_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern switches between never, now and then,
    // mostly, and long holds, each kept for a random stretch of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_result(o_out_data);
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (stall_left % 40) < 30;
            endcase
        end
    end

    // One write over the configuration port: setup phase, then access phase.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Blocks until every request has gone and every result has arrived.
    task automatic drain();
        while (send_queue.size() > 0 || i_in_valid || board.owed.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_req(t_action act, int r, int col, logic [31:0] val, bit lst);
        t_in_req q;
        q.action = act;
        q.row = r[2:0];
        q.column = col[2:0];
        q.value = val;
        q.last = lst;
        send_queue.push_back(q);
        item_count++;
    endtask

    function automatic logic [31:0] coord_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
        endcase
    endfunction

    function automatic logic [31:0] width_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom();
            2: return $urandom_range(1, 255);
            default: return ($urandom_range(0, 1) ? 32'h0 : 32'hffffffff)
                            ^ $urandom_range(32'h8000, 32'h01ffffff);
        endcase
    endfunction

    function automatic logic [31:0] basis_value();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $urandom_range(0, 32'h7fffffff) - 32'h40000000;
    endfunction

    // A random table entry, with last set at random since it is ignored there.
    task automatic queue_table_write();
        int k;
        k = $urandom_range(0, 2);
        queue_req(t_action'(k), $urandom_range(0, 7), $urandom_range(0, 7),
                  k == 0 ? basis_value() : (k == 1 ? coord_value() : width_value()),
                  $urandom_range(0, 1));
    endtask

    // A point of n coordinates in random order, the final one marked last.
    task automatic queue_point(int n);
        int order [8];
        int j;
        int t;
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < n; i++)
            queue_req(ACT_POINT, $urandom_range(0, 7), order[i], coord_value(), i == n - 1);
    endtask

    function automatic int pick_count();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(0, 15);
    endfunction

    initial begin
        int phase_items;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every table entry and the whole point buffer first.
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++) begin
                queue_req(ACT_BASIS, r, c, basis_value(), 1'b0);
                queue_req(ACT_CENTER, r, c, coord_value(), 1'b0);
                queue_req(ACT_WIDTH, r, c, width_value() | 32'h100, 1'b0);
            end
        queue_point(8);
        drain();

        // Directed: largest sizes in root mode, a zero width that saturates
        // centre 0, a negative width and extreme coordinates.
        write_reg(REG_DIMS, 32'd15);
        write_reg(REG_CENTERS, 32'd15);
        write_reg(REG_ROOT, 32'd1);
        queue_req(ACT_WIDTH, 0, 0, 32'h0, 1'b1);
        queue_req(ACT_WIDTH, 1, 3, 32'hffff0000, 1'b0);
        queue_req(ACT_CENTER, 1, 0, 32'h7fffffff, 1'b0);
        queue_req(ACT_BASIS, 7, 7, 32'h80000000, 1'b0);
        queue_req(ACT_POINT, 0, 0, 32'h80000000, 1'b0);
        queue_req(ACT_POINT, 0, 7, 32'h7fffffff, 1'b1);
        queue_req(ACT_POINT, 0, 1, 32'h0, 1'b1);
        drain();
        write_reg(REG_DIMS, 32'd0);
        write_reg(REG_CENTERS, 32'd0);
        write_reg(REG_ROOT, 32'd0);
        queue_req(ACT_POINT, 0, 0, 32'h7fffffff, 1'b1);
        queue_req(ACT_POINT, 0, 0, 32'h00010000, 1'b1);
        drain();
        write_reg(REG_DIMS, 32'd8);
        write_reg(REG_CENTERS, 32'd8);
        queue_req(ACT_POINT, 0, 2, 32'hffffffff, 1'b1);
        drain();

        // Random phases: a mix of table updates and points of one to eight
        // coordinates, with stray coordinates and ignored last flags as noise.
        while (item_count < 1850) begin
            write_reg(REG_DIMS, pick_count());
            write_reg(REG_CENTERS, pick_count());
            write_reg(REG_ROOT, $urandom_range(0, 1));
            phase_items = item_count + $urandom_range(30, 90);
            while (item_count < phase_items) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: queue_table_write();
                    4: queue_req(ACT_POINT, $urandom_range(0, 7), $urandom_range(0, 7),
                                 coord_value(), $urandom_range(0, 1));
                    default: queue_point($urandom_range(1, 8));
                endcase
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
